// ===== rtl/core/mms_pkg.sv =====
// types, codes and helpers shared by the motor mode sequencer
package mms_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int CFG_W = 16;
	localparam logic [CFG_W-1:0] GATE_CHARGE_RESET = 16'd100;

	// mode codes as they appear on the ports
	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_START = 3'd1,
		MODE_RUN   = 3'd2,
		MODE_SOFT  = 3'd3,
		MODE_HARD  = 3'd4,
		MODE_FAULT = 3'd5
	} mode_code_t;

	// start sub-step codes as they appear on the ports
	typedef enum logic [2:0] {
		STEP_IDLE   = 3'd0,
		STEP_VERIFY = 3'd1,
		STEP_ENABLE = 3'd2,
		STEP_WAIT   = 3'd3,
		STEP_DONE   = 3'd4
	} step_code_t;

	typedef enum logic [1:0] {
		OUTCOME_CONT = 2'd0,
		OUTCOME_DONE = 2'd1,
		OUTCOME_ERR  = 2'd2
	} outcome_t;

	// internal one-hot mode state
	typedef enum logic [5:0] {
		MS_IDLE  = 6'b000001,
		MS_START = 6'b000010,
		MS_RUN   = 6'b000100,
		MS_SOFT  = 6'b001000,
		MS_HARD  = 6'b010000,
		MS_FAULT = 6'b100000
	} mode_state_t;

	// internal one-hot start sub-step
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_VERIFY = 5'b00010,
		ST_ENABLE = 5'b00100,
		ST_WAIT   = 5'b01000,
		ST_DONE   = 5'b10000
	} step_state_t;

	typedef struct packed {
		logic       op;
		logic [2:0] requested_mode;
		logic       global_safety_ok;
		logic       channel_safety_ok;
		logic       output_enable_ok;
	} in_word_t;

	typedef struct packed {
		logic [2:0] mode_now;
		logic [2:0] start_step_now;
		logic       low_side_command;
		logic [1:0] step_outcome;
	} out_word_t;

	// next state and result word of one event
	typedef struct packed {
		mode_state_t mode;
		step_state_t step;
		out_word_t   word;
	} step_next_t;

	function automatic logic [2:0] mode_code(input mode_state_t m);
		logic [2:0] c;
		c = MODE_FAULT;
		unique case (m)
			MS_IDLE:  c = MODE_IDLE;
			MS_START: c = MODE_START;
			MS_RUN:   c = MODE_RUN;
			MS_SOFT:  c = MODE_SOFT;
			MS_HARD:  c = MODE_HARD;
			MS_FAULT: c = MODE_FAULT;
			default:  c = MODE_FAULT;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] step_code(input step_state_t s);
		logic [2:0] c;
		c = STEP_IDLE;
		unique case (s)
			ST_IDLE:   c = STEP_IDLE;
			ST_VERIFY: c = STEP_VERIFY;
			ST_ENABLE: c = STEP_ENABLE;
			ST_WAIT:   c = STEP_WAIT;
			ST_DONE:   c = STEP_DONE;
			default:   c = STEP_IDLE;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/mms_step.sv =====
// next-state and result logic for one input word: an adc event or a mode reset
module mms_step import mms_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  in_word_t               word,
	input  mode_state_t            mode,
	input  step_state_t            step,
	input  logic [COUNT_BITS-1:0]  count,
	input  logic [CFG_W-1:0]       gate_charge_events,
	output step_next_t             nxt,
	output logic [COUNT_BITS-1:0]  count_nxt
);

	localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

	logic [CMP_W-1:0]      count_x;
	logic [CMP_W-1:0]      gce_x;
	logic                  charged;
	outcome_t              res;
	logic                  low_side;
	logic                  clr;
	logic                  inv;
	step_state_t           step_n;
	mode_state_t           mode_n;
	logic [2:0]            req;
	logic [COUNT_BITS-1:0] count_base;

	assign count_x = CMP_W'(count);
	assign gce_x   = CMP_W'(gate_charge_events);
	assign charged = count_x >= gce_x;
	assign req     = word.requested_mode;

	// mode handler
	always_comb begin
		res      = OUTCOME_CONT;
		low_side = 1'b0;
		clr      = 1'b0;
		step_n   = step;
		unique case (mode) inside
			MS_IDLE, MS_SOFT, MS_HARD, MS_FAULT: res = OUTCOME_DONE;
			MS_RUN: res = OUTCOME_CONT;
			MS_START: begin
				unique case (step)
					ST_IDLE: step_n = ST_VERIFY;
					ST_VERIFY: begin
						if (word.global_safety_ok && word.channel_safety_ok) begin
							step_n = ST_ENABLE;
						end else begin
							step_n = ST_IDLE;
							res    = OUTCOME_ERR;
						end
					end
					ST_ENABLE: begin
						low_side = 1'b1;
						if (!word.output_enable_ok) begin
							step_n = ST_IDLE;
							res    = OUTCOME_ERR;
						end else begin
							clr    = 1'b1;
							step_n = ST_WAIT;
						end
					end
					ST_WAIT: begin
						if (charged) begin
							step_n = ST_DONE;
						end
					end
					ST_DONE: res = OUTCOME_DONE;
					default: res = OUTCOME_CONT;
				endcase
			end
			default: res = OUTCOME_ERR;
		endcase
	end

	// mode transition
	always_comb begin
		mode_n = mode;
		inv    = 1'b0;
		if (res == OUTCOME_DONE) begin
			unique case (mode)
				MS_IDLE: begin
					if (req == MODE_IDLE) mode_n = MS_IDLE;
					else if (req == MODE_RUN) mode_n = MS_START;
					else inv = 1'b1;
				end
				MS_START: begin
					if (req == MODE_RUN) mode_n = MS_RUN;
					else if (req == MODE_IDLE || req == MODE_SOFT || req == MODE_HARD)
						mode_n = MS_HARD;
					else inv = 1'b1;
				end
				MS_RUN: begin
					if (req == MODE_RUN || req == MODE_IDLE || req == MODE_SOFT)
						mode_n = MS_SOFT;
					else if (req == MODE_HARD) mode_n = MS_HARD;
					else inv = 1'b1;
				end
				MS_SOFT, MS_HARD: mode_n = MS_IDLE;
				MS_FAULT: begin
					if (req == MODE_IDLE) mode_n = MS_IDLE;
					else inv = 1'b1;
				end
				default: mode_n = mode;
			endcase
		end
		// stop requests take effect whatever the handler outcome, unless it is an error
		if (mode == MS_IDLE && req == MODE_IDLE) begin
			mode_n = MS_IDLE;
			inv    = 1'b0;
		end else if (mode == MS_START) begin
			if (req == MODE_IDLE || req == MODE_SOFT || req == MODE_HARD) begin
				mode_n = MS_HARD;
				inv    = 1'b0;
			end
		end else if (mode == MS_RUN) begin
			if (req == MODE_IDLE || req == MODE_SOFT) begin
				mode_n = MS_SOFT;
				inv    = 1'b0;
			end else if (req == MODE_HARD) begin
				mode_n = MS_HARD;
				inv    = 1'b0;
			end
		end
		if (inv || res == OUTCOME_ERR) begin
			mode_n = MS_FAULT;
		end
	end

	assign count_base = clr ? '0 : count;

	always_comb begin
		if (word.op) begin
			nxt.mode  = MS_IDLE;
			nxt.step  = ST_IDLE;
			nxt.word  = '0;
			count_nxt = '0;
		end else begin
			nxt.mode                  = mode_n;
			nxt.step                  = step_n;
			nxt.word.mode_now         = mode_code(mode_n);
			nxt.word.start_step_now   = step_code(step_n);
			nxt.word.low_side_command = low_side;
			nxt.word.step_outcome     = res;
			count_nxt = (&count_base) ? count_base : count_base + 1'b1;
		end
	end

endmodule

// ===== rtl/core/motor_mode_sequencer_top.sv =====
// top level of the motor mode sequencer
//
// one word on the input channel is one adc end-of-conversion event (op 0) or
// a mode reset (op 1); each produces exactly one result word on the output
// channel, in order
// both channels use valid/stall: a word moves on an edge with valid high and
// stall low; in_stall is driven here, out_stall by the consumer
// an accepted word waits in the input register, then the mode logic feeds
// the result register, which drives out_valid; a consumer stall can hold
// the word in the input register
// throughput is one word per cycle while the consumer does not stall; the
// mode, sub-step and charge counter update as a word leaves the input
// register, so back-to-back events see each other's state
// when the consumer stalls, the result register holds its word, the input
// register holds the next one, and in_stall rises only when both are full
// gate_charge_events is written through cfg_valid/cfg_ready/cfg_data; ready
// is always high, and writes are expected only while no word is in flight
// reset (arst_n low) clears the mode to idle, the sub-step to idle, the
// charge counter to zero, gate_charge_events to 100 and empties both stages
module motor_mode_sequencer_top import mms_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_word_t         in_word,
	output logic             out_valid,
	input  logic             out_stall,
	output out_word_t        out_word,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	// input register
	logic     valid_s1;
	in_word_t word_s1;

	// sequencer state
	mode_state_t           mode_q;
	step_state_t           step_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [CFG_W-1:0]      gce_q;

	// result register
	logic      out_valid_q;
	out_word_t out_word_q;

	step_next_t            nxt;
	logic [COUNT_BITS-1:0] count_nxt;
	logic                  advance;
	logic                  accept;

	// word leaves the input register when the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gce_q <= GATE_CHARGE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			gce_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= in_word;
		end
	end

	mms_step #(
		.COUNT_BITS(COUNT_BITS)
	) u_step (
		.word               (word_s1),
		.mode               (mode_q),
		.step               (step_q),
		.count              (count_q),
		.gate_charge_events (gce_q),
		.nxt                (nxt),
		.count_nxt          (count_nxt)
	);

	// state commits as the word moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MS_IDLE;
			step_q  <= ST_IDLE;
			count_q <= '0;
		end else if (advance) begin
			mode_q  <= nxt.mode;
			step_q  <= nxt.step;
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q <= nxt.word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// an error outcome always lands in fault
	a_err_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.step_outcome == OUTCOME_ERR |-> out_word.mode_now == MODE_FAULT)
		else $error("error outcome without fault mode");

	// low-side enable either moves on to the charge wait or fails back to idle
	a_low_side: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.low_side_command |->
			out_word.start_step_now == STEP_WAIT ||
			(out_word.start_step_now == STEP_IDLE && out_word.step_outcome == OUTCOME_ERR))
		else $error("low-side command with unexpected sub-step");

	// state registers stay one-hot
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(mode_q) && $onehot(step_q))
		else $error("mode or sub-step state not one-hot");

	// input side only stalls while holding a word that cannot move
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked word");

	// a charged counter never wraps
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(&count_q) && !(advance && (word_s1.op || step_q == ST_ENABLE)) |=> (&count_q))
		else $error("charge counter wrapped");

endmodule

// ===== tb/sv/tb_motor_mode_sequencer_top.sv =====
// self-checking testbench for the motor mode sequencer top level
`timescale 1ns / 1ps

module tb_motor_mode_sequencer_top import mms_pkg::*;;

	localparam int CHARGE_BITS = COUNT_BITS_DEF;
	localparam int IDLE_PCT = 15;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT = 5000;
	localparam int PARK_EVENTS = 40;
	localparam logic [CFG_W-1:0] PARK_GATE = 16'd30;

	// op field codes
	localparam logic OP_EVENT = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// request codes outside the mode list
	localparam logic [2:0] REQ_SPARE_A = 3'd6;
	localparam logic [2:0] REQ_SPARE_B = 3'd7;

	// marks an invalid transition inside the predictor
	localparam logic [2:0] MODE_BAD = 3'd6;

	// tracks mode, sub-step and charge counter and holds the expected words
	class mode_step_tracker;
		mode_code_t           mode_q;
		step_code_t           step_q;
		logic [CHARGE_BITS-1:0] charge_q;
		logic [CFG_W-1:0]     gate_q;
		out_word_t            pending_results[$];
		int                   errors;

		function new();
			mode_q   = MODE_IDLE;
			step_q   = STEP_IDLE;
			charge_q = '0;
			gate_q   = GATE_CHARGE_RESET;
			errors   = 0;
		endfunction

		// one accepted input word: advance the state, queue the result word
		function void note_event(in_word_t w);
			logic [2:0] req;
			logic [2:0] nxt;
			outcome_t   res;
			logic       low;
			out_word_t  want;
			req  = w.requested_mode;
			low  = 1'b0;
			want = '0;
			if (w.op == OP_CLEAR) begin
				mode_q   = MODE_IDLE;
				step_q   = STEP_IDLE;
				charge_q = '0;
			end else begin
				// handler of the current mode
				res = OUTCOME_DONE;
				case (mode_q)
					MODE_IDLE, MODE_SOFT, MODE_HARD, MODE_FAULT: res = OUTCOME_DONE;
					MODE_RUN: res = OUTCOME_CONT;
					MODE_START: begin
						res = OUTCOME_CONT;
						case (step_q)
							STEP_IDLE: step_q = STEP_VERIFY;
							STEP_VERIFY: begin
								if (w.global_safety_ok && w.channel_safety_ok) begin
									step_q = STEP_ENABLE;
								end else begin
									step_q = STEP_IDLE;
									res    = OUTCOME_ERR;
								end
							end
							STEP_ENABLE: begin
								low = 1'b1;
								if (!w.output_enable_ok) begin
									step_q = STEP_IDLE;
									res    = OUTCOME_ERR;
								end else begin
									charge_q = '0;
									step_q   = STEP_WAIT;
								end
							end
							STEP_WAIT: begin
								if (charge_q >= gate_q) step_q = STEP_DONE;
							end
							STEP_DONE: res = OUTCOME_DONE;
							default: res = OUTCOME_CONT;
						endcase
					end
					default: res = OUTCOME_ERR;
				endcase

				// transitions on a completed handler
				nxt = mode_q;
				if (res == OUTCOME_DONE) begin
					case (mode_q)
						MODE_IDLE: begin
							nxt = (req == MODE_IDLE) ? MODE_IDLE :
								(req == MODE_RUN) ? MODE_START : MODE_BAD;
						end
						MODE_START: begin
							if (req == MODE_RUN) nxt = MODE_RUN;
							else if (req == MODE_IDLE || req == MODE_SOFT || req == MODE_HARD)
								nxt = MODE_HARD;
							else nxt = MODE_BAD;
						end
						MODE_RUN: begin
							if (req == MODE_RUN || req == MODE_IDLE || req == MODE_SOFT)
								nxt = MODE_SOFT;
							else if (req == MODE_HARD) nxt = MODE_HARD;
							else nxt = MODE_BAD;
						end
						MODE_SOFT, MODE_HARD: nxt = MODE_IDLE;
						MODE_FAULT: nxt = (req == MODE_IDLE) ? MODE_IDLE : MODE_BAD;
						default: nxt = mode_q;
					endcase
				end

				// stop requests act whatever the outcome, unless it is an error
				if (mode_q == MODE_IDLE && req == MODE_IDLE) begin
					nxt = MODE_IDLE;
				end else if (mode_q == MODE_START) begin
					if (req == MODE_IDLE || req == MODE_SOFT || req == MODE_HARD) nxt = MODE_HARD;
				end else if (mode_q == MODE_RUN) begin
					if (req == MODE_IDLE || req == MODE_SOFT) nxt = MODE_SOFT;
					else if (req == MODE_HARD) nxt = MODE_HARD;
				end
				if (nxt == MODE_BAD || res == OUTCOME_ERR) nxt = MODE_FAULT;
				mode_q = mode_code_t'(nxt);

				// counter saturates at all ones
				if (charge_q != '1) charge_q = charge_q + 1'b1;

				want.mode_now         = mode_q;
				want.start_step_now   = step_q;
				want.low_side_command = low;
				want.step_outcome     = res;
			end
			pending_results.push_back(want);
		endfunction

		// one accepted result word against the oldest expectation
		function void check_result(out_word_t got);
			out_word_t want;
			if (pending_results.size() == 0) begin
				$error("result word %h with no expectation waiting", got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.mode_now !== want.mode_now) begin
				$error("mode_now: expected %0d, got %0d", want.mode_now, got.mode_now);
				errors++;
			end
			if (got.start_step_now !== want.start_step_now) begin
				$error("start_step_now: expected %0d, got %0d",
					want.start_step_now, got.start_step_now);
				errors++;
			end
			if (got.low_side_command !== want.low_side_command) begin
				$error("low_side_command: expected %0d, got %0d",
					want.low_side_command, got.low_side_command);
				errors++;
			end
			if (got.step_outcome !== want.step_outcome) begin
				$error("step_outcome: expected %0d, got %0d", want.step_outcome, got.step_outcome);
				errors++;
			end
		endfunction

		function void report_leftover();
			if (pending_results.size() != 0) begin
				$error("%0d result words never arrived", pending_results.size());
				errors++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	in_word_t         in_word = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_word_t        out_word;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;

	// calm: no idling on either side; long_hold: one long receiver hold-off
	bit calm = 1'b0;
	bit long_hold = 1'b0;

	mode_step_tracker tracker = new();

	always #1 clk = ~clk;

	motor_mode_sequencer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	function automatic in_word_t mk(input logic op, input logic [2:0] req,
		input logic g, input logic c, input logic oe);
		in_word_t w;
		w.op                = op;
		w.requested_mode    = req;
		w.global_safety_ok  = g;
		w.channel_safety_ok = c;
		w.output_enable_ok  = oe;
		return w;
	endfunction

	// random event, mostly a request that makes sense in the tracked mode
	function automatic in_word_t random_event();
		in_word_t w;
		int       roll;
		roll = $urandom_range(99);
		w.op                = (roll < 3) ? OP_CLEAR : OP_EVENT;
		w.global_safety_ok  = ($urandom_range(99) < 92);
		w.channel_safety_ok = ($urandom_range(99) < 92);
		w.output_enable_ok  = ($urandom_range(99) < 90);
		roll = $urandom_range(99);
		if ($urandom_range(99) < 15) begin
			w.requested_mode = 3'($urandom_range(7));
		end else begin
			case (tracker.mode_q)
				MODE_IDLE: w.requested_mode = (roll < 25) ? MODE_IDLE : MODE_RUN;
				MODE_START: begin
					if (tracker.step_q == STEP_DONE)
						w.requested_mode = (roll < 80) ? MODE_RUN : MODE_HARD;
					else if (roll < 90)
						w.requested_mode = MODE_START;
					else
						w.requested_mode = (roll < 94) ? MODE_SOFT : MODE_HARD;
				end
				MODE_RUN: begin
					if (roll < 75) w.requested_mode = MODE_RUN;
					else if (roll < 88) w.requested_mode = MODE_SOFT;
					else if (roll < 95) w.requested_mode = MODE_HARD;
					else w.requested_mode = MODE_IDLE;
				end
				MODE_FAULT: w.requested_mode = (roll < 80) ? MODE_IDLE : MODE_RUN;
				default: w.requested_mode = 3'($urandom_range(5));
			endcase
		end
		return w;
	endfunction

	// offer one word, hold it until taken, then note it
	task automatic send_word(input in_word_t w);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tracker.note_event(w);
	endtask

	task automatic run_random(input int count);
		for (int k = 0; k < count; k++) send_word(random_event());
	endtask

	// stop offering and wait until every expected word has come back or the drain limit runs out
	task automatic wait_drained();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		while (tracker.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
	endtask

	// gate charge register, written only with nothing in flight
	task automatic write_gate(input logic [CFG_W-1:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		tracker.gate_q = v;
	endtask

	// every taken result word is checked at the edge that takes it
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) tracker.check_result(out_word);
	end

	// receiver: random stall bursts, one long hold-off on request, none when calm
	initial begin
		forever begin
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end else if (!calm && $urandom_range(99) < IDLE_PCT) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at the reset gate charge value
		send_word(mk(OP_EVENT, MODE_IDLE, 1'b1, 1'b1, 1'b1));   // idle holds
		send_word(mk(OP_EVENT, MODE_START, 1'b1, 1'b1, 1'b1));  // start from idle is invalid
		send_word(mk(OP_EVENT, MODE_RUN, 1'b1, 1'b1, 1'b1));    // fault only leaves to idle
		send_word(mk(OP_EVENT, MODE_IDLE, 1'b1, 1'b1, 1'b1));
		send_word(mk(OP_EVENT, MODE_RUN, 1'b1, 1'b1, 1'b1));    // idle -> start
		send_word(mk(OP_EVENT, MODE_START, 1'b1, 1'b1, 1'b1));  // sub-step -> verify
		send_word(mk(OP_EVENT, MODE_START, 1'b0, 1'b1, 1'b1));  // global safety fails
		send_word(mk(OP_EVENT, MODE_IDLE, 1'b1, 1'b1, 1'b1));
		send_word(mk(OP_EVENT, MODE_RUN, 1'b1, 1'b1, 1'b1));
		send_word(mk(OP_EVENT, MODE_START, 1'b1, 1'b1, 1'b1));
		send_word(mk(OP_EVENT, MODE_START, 1'b1, 1'b0, 1'b1));  // channel safety fails
		send_word(mk(OP_CLEAR, REQ_SPARE_B, 1'b0, 1'b0, 1'b0)); // mode reset, junk fields
		send_word(mk(OP_EVENT, MODE_RUN, 1'b1, 1'b1, 1'b1));
		send_word(mk(OP_EVENT, MODE_START, 1'b1, 1'b1, 1'b1));
		send_word(mk(OP_EVENT, MODE_START, 1'b1, 1'b1, 1'b0));  // -> enable low side
		send_word(mk(OP_EVENT, MODE_START, 1'b1, 1'b1, 1'b0));  // output enable fails
		send_word(mk(OP_CLEAR, MODE_IDLE, 1'b1, 1'b1, 1'b1));
		send_word(mk(OP_EVENT, MODE_RUN, 1'b1, 1'b1, 1'b1));
		send_word(mk(OP_EVENT, MODE_START, 1'b1, 1'b1, 1'b1));
		send_word(mk(OP_EVENT, MODE_START, 1'b1, 1'b1, 1'b1));
		send_word(mk(OP_EVENT, MODE_START, 1'b0, 1'b0, 1'b1));  // enable ok -> wait charge
		send_word(mk(OP_EVENT, MODE_START, 1'b1, 1'b1, 1'b1));  // still charging
		send_word(mk(OP_EVENT, MODE_FAULT, 1'b1, 1'b1, 1'b1));  // start holds on fault request
		send_word(mk(OP_EVENT, MODE_SOFT, 1'b1, 1'b1, 1'b1));   // start -> hard stop
		send_word(mk(OP_EVENT, REQ_SPARE_A, 1'b1, 1'b1, 1'b1)); // hard stop -> idle on anything
		send_word(mk(OP_EVENT, REQ_SPARE_B, 1'b1, 1'b1, 1'b1)); // unlisted request -> fault
		send_word(mk(OP_CLEAR, MODE_HARD, 1'b1, 1'b1, 1'b1));

		// zero wait: start completes on the first charge event
		write_gate('0);
		run_random(270);

		// short wait, with the receiver holding off long enough to back up the input
		write_gate(16'd3);
		run_random(130);
		long_hold = 1'b1;
		run_random(140);

		// longer wait: park the sub-step in wait charge, let the counter run
		// past the setting while away, then come back and see the wait end at once
		write_gate(PARK_GATE);
		send_word(mk(OP_CLEAR, MODE_IDLE, 1'b1, 1'b1, 1'b1));
		send_word(mk(OP_EVENT, MODE_RUN, 1'b1, 1'b1, 1'b1));
		send_word(mk(OP_EVENT, MODE_START, 1'b1, 1'b1, 1'b1));
		send_word(mk(OP_EVENT, MODE_START, 1'b1, 1'b1, 1'b1));
		send_word(mk(OP_EVENT, MODE_START, 1'b1, 1'b1, 1'b1));
		send_word(mk(OP_EVENT, MODE_START, 1'b1, 1'b1, 1'b1));
		send_word(mk(OP_EVENT, MODE_HARD, 1'b1, 1'b1, 1'b1));
		send_word(mk(OP_EVENT, MODE_IDLE, 1'b1, 1'b1, 1'b1));
		for (int k = 0; k < PARK_EVENTS; k++) begin
			send_word(mk(OP_EVENT, MODE_IDLE, 1'($urandom_range(1)), 1'($urandom_range(1)),
				1'($urandom_range(1))));
		end
		send_word(mk(OP_EVENT, MODE_RUN, 1'b1, 1'b1, 1'b1));
		send_word(mk(OP_EVENT, MODE_START, 1'b1, 1'b1, 1'b1));
		send_word(mk(OP_EVENT, MODE_RUN, 1'b1, 1'b1, 1'b1));
		run_random(270);

		write_gate(16'd1);
		run_random(270);

		// random setting, quiet tail with no idling on either side
		write_gate(CFG_W'($urandom_range(2, 40)));
		run_random(120);
		calm = 1'b1;
		run_random(150);

		wait_drained();
		repeat (8) @(posedge clk);
		tracker.report_leftover();
		if (tracker.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// overall time limit
	initial begin
		#20000000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/mms_pkg.sv
rtl/core/mms_step.sv
rtl/core/motor_mode_sequencer_top.sv
tb/sv/tb_motor_mode_sequencer_top.sv
